// ----- rtl/core/multi_sensor_fifo_drain_controller_assert.svh -----
// Assertion macros for the multi-sensor FIFO drain controller.
// Expects signals named clock and reset in the including scope.
`ifndef MULTI_SENSOR_FIFO_DRAIN_CONTROLLER_ASSERT_SVH
`define MULTI_SENSOR_FIFO_DRAIN_CONTROLLER_ASSERT_SVH

// Condition that holds at every edge out of reset.
`define MSFDC_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next.
`define MSFDC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/msfdc_pkg.sv -----
// Shared types and constants for the multi-sensor FIFO drain controller.
// No dependencies; used by the channel interfaces and the top level.
package msfdc_pkg;

   localparam int Sensors = 4;
   localparam logic [9:0] MaxDrain = 10'd512;
   localparam logic [7:0] SensorMask = 8'((1 << Sensors) - 1);
   localparam logic [4:0] SampleTag = 5'd2;
   localparam logic [1:0] CountHighMask = 2'b11;
   localparam int OverrunBit = 6;

   typedef enum logic [2:0] {
      ModeWatermark = 3'd0,
      ModeService   = 3'd1,
      ModeWord      = 3'd2,
      ModeComplete  = 3'd3,
      ModeBusError  = 3'd4
   } mode_type;

   typedef enum logic [3:0] {
      KindMarked     = 4'd0,
      KindIgnored    = 4'd1,
      KindIdle       = 4'd2,
      KindStatusFail = 4'd3,
      KindEmpty      = 4'd4,
      KindStarted    = 4'd5,
      KindStartFail  = 4'd6,
      KindSample     = 4'd7,
      KindSkipped    = 4'd8,
      KindComplete   = 4'd9,
      KindError      = 4'd10
   } kind_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [2:0]  sensor;
      logic [7:0]  status_low;
      logic [7:0]  status_high;
      logic        status_ok;
      logic        start_ok;
      logic [7:0]  tag_byte;
      logic [47:0] word_data;
   } req_type;

   typedef struct packed {
      kind_type           kind;
      logic [2:0]         sensor_out;
      logic [9:0]         word_count;
      logic [12:0]        byte_count;
      logic signed [15:0] sample_x;
      logic signed [15:0] sample_y;
      logic signed [15:0] sample_z;
      logic [9:0]         sample_index;
      logic [15:0]        overrun_count;
      logic [15:0]        error_count;
   } rsp_type;

endpackage

// ----- rtl/core/msfdc_req_if.sv -----
// Request channel: valid/ready handshake carrying one event or FIFO word.
// Depends on msfdc_pkg for the payload type.
interface msfdc_req_if;
   logic               valid;
   logic               ready;
   msfdc_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/core/msfdc_rsp_if.sv -----
// Response channel: valid/ready handshake carrying one result.
// Depends on msfdc_pkg for the payload type.
interface msfdc_rsp_if;
   logic               valid;
   logic               ready;
   msfdc_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/core/multi_sensor_fifo_drain_controller.sv -----
// Drain controller for the FIFOs of several accelerometers on one bus. Each request
// transfer (watermark, service, FIFO word, burst complete, bus error) gives exactly one
// response transfer. Sustained rate is one item per clock while responses are taken.
// A result is held first in the input register, then in the result register, and is
// offered from the result register. The state update and decode sit between those two
// registers, so the rate is set by that single pass. Both sides stall independently;
// the input register takes a new item whenever it is empty or its item moves on to the
// result register in the same cycle.
// Depends on msfdc_pkg, msfdc_req_if, msfdc_rsp_if and the assertion header.
`include "multi_sensor_fifo_drain_controller_assert.svh"

module multi_sensor_fifo_drain_controller (
   input logic         clock,
   input logic         reset,
   msfdc_req_if.sink   req_chan,
   msfdc_rsp_if.source rsp_chan
);

   msfdc_pkg::req_type in_ff;
   logic               in_valid_ff;
   msfdc_pkg::rsp_type out_ff, res;
   logic               out_valid_ff;
   logic               advance;

   logic [7:0]  pending_ff, pending_in;
   logic        busy_ff, busy_in;
   logic [2:0]  active_ff, active_in;
   logic [9:0]  burst_ff, burst_in;
   logic [9:0]  seen_ff, seen_in;
   logic [9:0]  samples_ff, samples_in;
   logic [15:0] overruns_ff, overruns_in;
   logic [15:0] failures_ff, failures_in;

   logic        found;
   logic [2:0]  sel;
   logic [9:0]  words_raw, words;
   logic [7:0]  active_bit;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.payload = out_ff;

   // lowest pending sensor wins
   always_comb begin
      found = 1'b0;
      sel   = 3'd0;
      for (int i = msfdc_pkg::Sensors - 1; i >= 0; i--) begin
         if (pending_ff[i]) begin
            found = 1'b1;
            sel   = 3'(i);
         end
      end
   end

   assign words_raw  = {in_ff.status_high[1:0] & msfdc_pkg::CountHighMask,
                        in_ff.status_low};
   assign words      = (words_raw > msfdc_pkg::MaxDrain) ? msfdc_pkg::MaxDrain : words_raw;
   assign active_bit = 8'b1 << active_ff;

   always_comb begin
      pending_in  = pending_ff;
      busy_in     = busy_ff;
      active_in   = active_ff;
      burst_in    = burst_ff;
      seen_in     = seen_ff;
      samples_in  = samples_ff;
      overruns_in = overruns_ff;
      failures_in = failures_ff;

      res              = '0;
      res.kind         = msfdc_pkg::KindIgnored;
      res.sensor_out   = active_ff;

      unique case (in_ff.mode)
         msfdc_pkg::ModeWatermark: begin
            res.sensor_out = in_ff.sensor;
            if (32'(in_ff.sensor) < msfdc_pkg::Sensors) begin
               pending_in = pending_ff | (8'b1 << in_ff.sensor);
               res.kind   = msfdc_pkg::KindMarked;
            end
         end
         msfdc_pkg::ModeService: begin
            if (busy_ff || !found) begin
               res.kind = msfdc_pkg::KindIdle;
            end else begin
               pending_in     = pending_ff & ~(8'b1 << sel);
               res.sensor_out = sel;
               if (!in_ff.status_ok) begin
                  res.kind = msfdc_pkg::KindStatusFail;
               end else begin
                  if (in_ff.status_high[msfdc_pkg::OverrunBit])
                     overruns_in = overruns_ff + 16'd1;
                  if (words_raw == 10'd0) begin
                     res.kind = msfdc_pkg::KindEmpty;
                  end else begin
                     active_in      = sel;
                     burst_in       = words;
                     seen_in        = 10'd0;
                     samples_in     = 10'd0;
                     res.word_count = words;
                     // 1 + 7 * words, as 8 * words - words + 1
                     res.byte_count = {words, 3'b000} - {3'b000, words} + 13'd1;
                     if (in_ff.start_ok) begin
                        busy_in  = 1'b1;
                        res.kind = msfdc_pkg::KindStarted;
                     end else begin
                        busy_in     = 1'b0;
                        failures_in = failures_ff + 16'd1;
                        res.kind    = msfdc_pkg::KindStartFail;
                     end
                  end
               end
            end
         end
         msfdc_pkg::ModeWord: begin
            res.kind = msfdc_pkg::KindSkipped;
            if (busy_ff && seen_ff < burst_ff) begin
               seen_in = seen_ff + 10'd1;
               if (in_ff.tag_byte[7:3] == msfdc_pkg::SampleTag &&
                   samples_ff < msfdc_pkg::MaxDrain) begin
                  res.sample_x     = in_ff.word_data[15:0];
                  res.sample_y     = in_ff.word_data[31:16];
                  res.sample_z     = in_ff.word_data[47:32];
                  res.sample_index = samples_ff;
                  samples_in       = samples_ff + 10'd1;
                  res.kind         = msfdc_pkg::KindSample;
               end
            end
         end
         msfdc_pkg::ModeComplete: begin
            if (busy_ff) begin
               busy_in          = 1'b0;
               pending_in       = pending_ff | active_bit;
               res.sample_index = samples_ff;
               res.kind         = msfdc_pkg::KindComplete;
            end
         end
         msfdc_pkg::ModeBusError: begin
            busy_in     = 1'b0;
            failures_in = failures_ff + 16'd1;
            pending_in  = pending_ff | active_bit;
            res.kind    = msfdc_pkg::KindError;
         end
         default: begin
            res.kind = msfdc_pkg::KindIgnored;
         end
      endcase

      res.overrun_count = overruns_in;
      res.error_count   = failures_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pending_ff   <= '0;
         busy_ff      <= 1'b0;
         active_ff    <= '0;
         burst_ff     <= '0;
         seen_ff      <= '0;
         samples_ff   <= '0;
         overruns_ff  <= '0;
         failures_ff  <= '0;
      end else begin
         if (req_chan.ready)
            in_valid_ff <= req_chan.valid;
         if (advance)
            out_valid_ff <= 1'b1;
         else if (rsp_chan.ready)
            out_valid_ff <= 1'b0;
         if (advance) begin
            pending_ff  <= pending_in;
            busy_ff     <= busy_in;
            active_ff   <= active_in;
            burst_ff    <= burst_in;
            seen_ff     <= seen_in;
            samples_ff  <= samples_in;
            overruns_ff <= overruns_in;
            failures_ff <= failures_in;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready)
         in_ff <= req_chan.payload;
      if (advance)
         out_ff <= res;
   end

   `MSFDC_ASSERT_ALWAYS(pending_in_range, (pending_ff & ~msfdc_pkg::SensorMask) == 8'd0, "pending bit beyond sensor count")
   `MSFDC_ASSERT_ALWAYS(active_in_range, 32'(active_ff) < msfdc_pkg::Sensors, "active sensor out of range")
   `MSFDC_ASSERT_ALWAYS(seen_within_burst, seen_ff <= burst_ff, "more words seen than burst holds")
   `MSFDC_ASSERT_ALWAYS(samples_within_seen, samples_ff <= seen_ff, "more samples than words seen")
   `MSFDC_ASSERT_NEXT(start_sets_busy, advance && res.kind == msfdc_pkg::KindStarted, busy_ff, "started burst did not set busy")

endmodule

// ----- sim/msfdc_drain_checker.sv -----
// Scoreboard for the multi-sensor FIFO drain controller: watches both channels,
// predicts every response from the request stream and compares field by field.
// Depends on msfdc_pkg and the msfdc_req_if / msfdc_rsp_if interfaces.
module msfdc_drain_checker (
   input  logic  clock,
   input  logic  reset,
   msfdc_req_if  req_mon,
   msfdc_rsp_if  rsp_mon,
   output int    mismatches,
   output int    outstanding
);
   import msfdc_pkg::*;

   logic [7:0]  marked_set;
   logic        draining;
   logic [2:0]  cur_sensor;
   logic [9:0]  burst_len;
   logic [9:0]  words_taken;
   logic [10:0] samples_taken;
   logic [15:0] overrun_total;
   logic [15:0] failure_total;

   rsp_type     expected_rsps[$];
   int          reported;

   // Advances the shadow state by one request and returns the response it causes.
   function automatic rsp_type drain_predict(input req_type r);
      rsp_type    o;
      logic [2:0] pick;
      logic       found;
      logic [9:0] words;
      o = '0;
      o.kind = KindIgnored;
      o.sensor_out = cur_sensor;
      found = 1'b0;
      pick = '0;
      case (r.mode)
         ModeWatermark: begin
            o.sensor_out = r.sensor;
            if (r.sensor < Sensors) begin
               marked_set[r.sensor] = 1'b1;
               o.kind = KindMarked;
            end
         end
         ModeService: begin
            for (int i = Sensors - 1; i >= 0; i--) begin
               if (marked_set[i]) begin
                  found = 1'b1;
                  pick = 3'(i);
               end
            end
            if (draining || !found) begin
               o.kind = KindIdle;
            end else begin
               marked_set[pick] = 1'b0;
               o.sensor_out = pick;
               if (!r.status_ok) begin
                  o.kind = KindStatusFail;
               end else begin
                  words = {r.status_high[1:0], r.status_low};
                  if (r.status_high[OverrunBit])
                     overrun_total = overrun_total + 16'd1;
                  if (words == '0) begin
                     o.kind = KindEmpty;
                  end else begin
                     if (words > MaxDrain)
                        words = MaxDrain;
                     cur_sensor = pick;
                     burst_len = words;
                     words_taken = '0;
                     samples_taken = '0;
                     o.word_count = words;
                     o.byte_count = 13'd1 + 13'(words) * 13'd7;
                     if (r.start_ok) begin
                        draining = 1'b1;
                        o.kind = KindStarted;
                     end else begin
                        draining = 1'b0;
                        failure_total = failure_total + 16'd1;
                        o.kind = KindStartFail;
                     end
                  end
               end
            end
         end
         ModeWord: begin
            o.kind = KindSkipped;
            if (draining && words_taken < burst_len) begin
               words_taken = words_taken + 10'd1;
               if (r.tag_byte[7:3] == SampleTag && samples_taken < {1'b0, MaxDrain}) begin
                  o.sample_x = r.word_data[15:0];
                  o.sample_y = r.word_data[31:16];
                  o.sample_z = r.word_data[47:32];
                  o.sample_index = samples_taken[9:0];
                  samples_taken = samples_taken + 11'd1;
                  o.kind = KindSample;
               end
            end
         end
         ModeComplete: begin
            if (draining) begin
               draining = 1'b0;
               marked_set[cur_sensor] = 1'b1;
               o.sample_index = samples_taken[9:0];
               o.kind = KindComplete;
            end
         end
         ModeBusError: begin
            // re-marks the active sensor whether or not a burst is running
            draining = 1'b0;
            failure_total = failure_total + 16'd1;
            marked_set[cur_sensor] = 1'b1;
            o.kind = KindError;
         end
         default: ;
      endcase
      o.overrun_count = overrun_total;
      o.error_count = failure_total;
      return o;
   endfunction

   function automatic string rsp_text(input rsp_type p);
      return $sformatf("kind=%0d sensor=%0d words=%0d bytes=%0d x=%0d y=%0d z=%0d idx=%0d ovr=%0d err=%0d",
         p.kind, p.sensor_out, p.word_count, p.byte_count, p.sample_x, p.sample_y,
         p.sample_z, p.sample_index, p.overrun_count, p.error_count);
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         marked_set    = '0;
         draining      = 1'b0;
         cur_sensor    = '0;
         burst_len     = '0;
         words_taken   = '0;
         samples_taken = '0;
         overrun_total = '0;
         failure_total = '0;
         expected_rsps.delete();
         mismatches    <= 0;
         reported      = 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            expected_rsps.push_back(drain_predict(req_mon.payload));
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = rsp_mon.payload;
            if (expected_rsps.size() == 0) begin
               mismatches <= mismatches + 1;
               if (reported < 10)
                  $display("unexpected response transfer: %s", rsp_text(got));
               reported++;
            end else begin
               want = expected_rsps.pop_front();
               if (got.kind !== want.kind || got.sensor_out !== want.sensor_out ||
                   got.word_count !== want.word_count || got.byte_count !== want.byte_count ||
                   got.sample_x !== want.sample_x || got.sample_y !== want.sample_y ||
                   got.sample_z !== want.sample_z || got.sample_index !== want.sample_index ||
                   got.overrun_count !== want.overrun_count ||
                   got.error_count !== want.error_count) begin
                  mismatches <= mismatches + 1;
                  if (reported < 10) begin
                     $display("response mismatch, expected: %s", rsp_text(want));
                     $display("                   actual:   %s", rsp_text(got));
                  end
                  reported++;
               end
            end
         end
      end
      outstanding <= expected_rsps.size();
   end

endmodule

// ----- sim/tb_multi_sensor_fifo_drain_controller.sv -----
// Testbench top for the multi-sensor FIFO drain controller: clock, reset, request
// stimulus and response back-pressure; checking is done by msfdc_drain_checker.
// Depends on msfdc_pkg, both channel interfaces, the controller and the checker.
module tb_multi_sensor_fifo_drain_controller;
   import msfdc_pkg::*;

   localparam logic [2:0] ModeUnusedFirst = 3'd5;
   localparam logic [2:0] ModeUnusedLast  = 3'd7;
   localparam int         ItemTarget      = 1550;
   localparam int         HoldCycles      = 120;

   logic clock = 1'b0;
   logic reset;
   int   mismatches;
   int   outstanding;
   int   sent = 0;
   bit   calm = 1'b0;

   msfdc_req_if req_chan ();
   msfdc_rsp_if rsp_chan ();

   multi_sensor_fifo_drain_controller dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   msfdc_drain_checker u_drain_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic req_type rand_req(input logic [2:0] m);
      req_type r;
      r.mode        = m;
      r.sensor      = 3'($urandom);
      r.status_low  = 8'($urandom);
      r.status_high = 8'($urandom);
      r.status_ok   = 1'($urandom);
      r.start_ok    = 1'($urandom);
      r.tag_byte    = 8'($urandom);
      r.word_data   = {16'($urandom), 32'($urandom)};
      return r;
   endfunction

   // One request transfer, then an occasional idle gap on the sender side.
   task automatic push_item(input req_type item);
      int gap;
      req_chan.valid   <= 1'b1;
      req_chan.payload <= item;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sent++;
      calm = (sent >= 700 && sent < 900);
      if (!calm && $urandom_range(0, 99) < 16) begin
         gap = $urandom_range(1, 4);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic push_event(input logic [2:0] m);
      push_item(rand_req(m));
   endtask

   task automatic mark_sensor(input int s);
      req_type r;
      r = rand_req(ModeWatermark);
      r.sensor = 3'(s);
      push_item(r);
   endtask

   task automatic request_service(input logic [9:0] words, input bit ovr,
                                  input bit st_ok, input bit go_ok);
      req_type r;
      r = rand_req(ModeService);
      r.status_low              = words[7:0];
      r.status_high[1:0]        = words[9:8];
      r.status_high[OverrunBit] = ovr;
      r.status_ok               = st_ok;
      r.start_ok                = go_ok;
      push_item(r);
   endtask

   task automatic push_word(input logic [4:0] tag);
      req_type r;
      r = rand_req(ModeWord);
      r.tag_byte[7:3] = tag;
      push_item(r);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   initial begin
      int  words;
      int  burst;
      int  stream;
      int  big_bursts;
      bit  paused;
      big_bursts = 0;
      paused = 1'b0;
      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.payload <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed opening
      request_service(10'd4, 1'b0, 1'b1, 1'b1);    // nothing pending
      mark_sensor(0);
      mark_sensor(1);
      mark_sensor(2);
      mark_sensor(3);
      mark_sensor(4);                              // out of range
      mark_sensor(7);
      request_service(10'd0, 1'b1, 1'b1, 1'b1);    // empty FIFO with overrun
      request_service(10'd5, 1'b1, 1'b0, 1'b1);    // status read fails
      request_service(10'h3FF, 1'b1, 1'b1, 1'b0);  // clamped, start fails
      push_event(ModeComplete);                    // complete while idle
      push_word(SampleTag);                        // word while idle
      request_service(10'd3, 1'b0, 1'b1, 1'b1);
      push_word(SampleTag);
      push_word(5'h1F);                            // wrong tag
      push_word(SampleTag);
      push_word(SampleTag);                        // beyond burst count
      request_service(10'd2, 1'b0, 1'b1, 1'b1);    // busy
      push_event(ModeComplete);
      request_service(10'd1, 1'b0, 1'b1, 1'b1);
      push_event(ModeBusError);
      push_event(ModeBusError);                    // error while idle
      push_event(ModeUnusedFirst);
      push_event(ModeUnusedLast);

      while (sent < ItemTarget) begin
         if (!paused && sent >= 1100) begin
            paused = 1'b1;
            wait_drained();
         end
         if ($urandom_range(0, 99) < 20) begin
            push_event(3'($urandom_range(0, 7)));
         end else begin
            repeat ($urandom_range(1, 3)) begin
               if ($urandom_range(0, 7) == 0)
                  mark_sensor($urandom_range(0, 7));
               else
                  mark_sensor($urandom_range(0, Sensors - 1));
            end
            if (big_bursts < 2 && sent < 900 && $urandom_range(0, 29) == 0) begin
               big_bursts++;
               words = $urandom_range(int'(MaxDrain), 1023);
            end else if ($urandom_range(0, 9) == 0) begin
               words = 0;
            end else begin
               words = $urandom_range(1, 12);
            end
            request_service(10'(words), $urandom_range(0, 3) == 0,
                            $urandom_range(0, 19) != 0, $urandom_range(0, 9) != 0);
            burst = (words > int'(MaxDrain)) ? int'(MaxDrain) : words;
            stream = ($urandom_range(0, 4) == 0) ? $urandom_range(0, burst + 2) : burst;
            repeat (stream) begin
               if ($urandom_range(0, 4) == 0)
                  push_word(5'($urandom));
               else
                  push_word(SampleTag);
            end
            if ($urandom_range(0, 5) == 0)
               push_event(ModeBusError);
            else
               push_event(ModeComplete);
         end
      end

      wait_drained();
      repeat (4) @(posedge clock);
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Response side: random back-pressure plus one long hold so the input stalls.
   initial begin
      int  held;
      bit  hold_done;
      hold_done = 1'b0;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!hold_done && sent >= 400) begin
            hold_done = 1'b1;
            rsp_chan.ready <= 1'b0;
            held = 0;
            while (held < HoldCycles) begin
               @(posedge clock);
               held++;
            end
         end else begin
            rsp_chan.ready <= calm || ($urandom_range(0, 99) >= 16);
            @(posedge clock);
         end
      end
   end

   initial begin
      #400000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ----- multi_sensor_fifo_drain_controller.f -----
+incdir+rtl/core
rtl/core/msfdc_pkg.sv
rtl/core/msfdc_req_if.sv
rtl/core/msfdc_rsp_if.sv
rtl/core/multi_sensor_fifo_drain_controller.sv
sim/msfdc_drain_checker.sv
sim/tb_multi_sensor_fifo_drain_controller.sv
